### rtl/bmpd_pkg.sv
package bmpd_pkg;

   // Parser phases, one-hot.
   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_SKIP   = 5'b00010,
      PH_PIXEL  = 5'b00100,
      PH_PAD    = 5'b01000,
      PH_DRAIN  = 5'b10000
   } phase_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_PIXEL  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // Error codes.
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SIGNATURE = 3'd1,
      ERR_VERSION   = 3'd2,
      ERR_FORMAT    = 3'd3,
      ERR_TOO_LARGE = 3'd4,
      ERR_OFFSET    = 3'd5,
      ERR_TRUNCATED = 3'd6
   } err_type;

   // Header layout and accepted values.
   localparam logic [15:0] SIG_BM    = 16'h4d42;
   localparam logic [31:0] INFO_LEN  = 32'd40;
   localparam logic [15:0] BPP_24    = 16'd24;
   localparam logic [5:0]  SIG_AT    = 6'd0;
   localparam logic [5:0]  OFS_AT    = 6'd10;
   localparam logic [5:0]  INFO_AT   = 6'h0e;
   localparam logic [5:0]  WIDTH_AT  = INFO_AT + 6'd4;
   localparam logic [5:0]  HEIGHT_AT = INFO_AT + 6'd8;
   localparam logic [5:0]  BPP_AT    = INFO_AT + 6'h0e;
   localparam logic [5:0]  COMP_AT   = INFO_AT + 6'h10;
   localparam logic [5:0]  HDR_LAST  = INFO_AT + 6'd39;
   localparam logic [31:0] HDR_LEN   = 32'd54;

   // Configuration port.
   localparam int          CSR_AW       = 3;
   localparam logic        CSR_IDX_SWAP = 1'b0;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      err_type     code;
      logic [12:0] width;
      logic [12:0] height;
      logic [23:0] addr;
      logic [23:0] value;
      logic        done;
   } rsp_type;

endpackage

### rtl/bmp24_stream_decoder.sv
// Streaming decoder for 24-bit uncompressed BMP files. Feed the file one byte per item in
// file order and mark the last byte with end_of_file. The block takes one item per clock
// cycle while req_stall is low: each byte updates the header capture, skip, pixel or
// padding counters in a single pass and its result, if any, is registered in the output
// register when the byte is accepted. req_stall is high only while a result sits in that
// register and rsp_stall holds it, so the sustained rate is one byte per cycle whenever
// the result side keeps up. A header result gives the dimensions, each third pixel byte
// gives a pixel item with its top-down frame address, and any failure gives one error
// item after which bytes are ignored up to end of file. swap_channels (register 0)
// reverses the three color bytes of each pixel; write it only while the block is idle.
module bmp24_stream_decoder #(
   parameter int MAX_DIM = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_end_of_file,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output logic [2:0]                    rsp_error_code,
   output logic [12:0]                   rsp_image_width,
   output logic [12:0]                   rsp_image_height,
   output logic [23:0]                   rsp_pixel_address,
   output logic [23:0]                   rsp_pixel_value,
   output logic                          rsp_image_done,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bmpd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic              swap_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   bmpd_pkg::rsp_type rsp_ff;
   logic              advance;
   logic              accept;
   logic              res_valid;
   bmpd_pkg::rsp_type res;
   logic              csr_hit;

   // Output register moves unless a held result is stalled.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   bmpd_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (accept),
      .data_byte     (req_data_byte),
      .end_of_file   (req_end_of_file),
      .swap_channels (swap_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // Result register.
   assign rsp_valid_in = advance ? res_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_ff.kind;
   assign rsp_error_code    = rsp_ff.code;
   assign rsp_image_width   = rsp_ff.width;
   assign rsp_image_height  = rsp_ff.height;
   assign rsp_pixel_address = rsp_ff.addr;
   assign rsp_pixel_value   = rsp_ff.value;
   assign rsp_image_done    = rsp_ff.done;

   // Configuration register file.
   assign csr_hit    = (csr_paddr[bmpd_pkg::CSR_AW-1:2] == bmpd_pkg::CSR_IDX_SWAP);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {31'd0, swap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         swap_ff <= csr_pwdata[0];
      end
   end

`ifndef SYNTHESIS
   // An error item always closes the image.
   a_error_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == bmpd_pkg::KIND_ERROR |-> rsp_image_done)
      else $error("error item without image_done");

   // An error code is given exactly on error items.
   a_code_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_result_kind == bmpd_pkg::KIND_ERROR) ==
                     (rsp_error_code != bmpd_pkg::ERR_NONE)))
      else $error("error code does not match result kind");

   // The input side is held back only by a pending result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");
`endif

endmodule

### rtl/bmpd_parser.sv
module bmpd_parser #(
   parameter int MAX_DIM = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                end_of_file,
   input  logic                swap_channels,
   output logic                res_valid,
   output bmpd_pkg::rsp_type   res
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   bmpd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         count_ff, count_in;
   logic [15:0]         sig_ff, sig_in;
   logic [31:0]         ofs_ff, ofs_in;
   logic [31:0]         info_ff, info_in;
   logic [31:0]         width_ff, width_in;
   logic [31:0]         height_ff, height_in;
   logic [15:0]         bpp_ff, bpp_in;
   logic [31:0]         comp_ff, comp_in;
   logic [1:0]          bip_ff, bip_in;
   logic [15:0]         partial_ff, partial_in;
   logic [DIM_W-1:0]    column_ff, column_in;
   logic [DIM_W-1:0]    rows_ff, rows_in;
   logic [23:0]         row_base_ff, row_base_in;
   logic [1:0]          pad_ff, pad_in;

   logic [5:0]          hdr_idx;
   logic [DIM_W-1:0]    col_inc;
   logic [2*DIM_W-1:0]  base_prod;
   bmpd_pkg::err_type   err;

   // Little-endian byte capture into a header field.
   function automatic logic [31:0] put_le(input logic [31:0] r, input logic [5:0] idx,
                                          input logic [5:0] start, input logic [2:0] len,
                                          input logic [7:0] b);
      logic [31:0] v;
      logic [5:0]  lane;
      v    = r;
      lane = idx - start;
      if (idx >= start && idx < start + 6'(len)) begin
         case (lane[1:0])
            2'd0:    v[7:0]   = b;
            2'd1:    v[15:8]  = b;
            2'd2:    v[23:16] = b;
            default: v[31:24] = b;
         endcase
      end
      return v;
   endfunction

   assign hdr_idx   = count_ff[5:0];
   assign col_inc   = column_ff + DIM_W'(1);
   assign base_prod = (DIM_W'(height_ff) - DIM_W'(1)) * DIM_W'(width_ff);

   // Next state and result for the accepted byte.
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      sig_in      = sig_ff;
      ofs_in      = ofs_ff;
      info_in     = info_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      bpp_in      = bpp_ff;
      comp_in     = comp_ff;
      bip_in      = bip_ff;
      partial_in  = partial_ff;
      column_in   = column_ff;
      rows_in     = rows_ff;
      row_base_in = row_base_ff;
      pad_in      = pad_ff;
      err         = bmpd_pkg::ERR_NONE;
      res_valid   = 1'b0;
      res         = '0;

      if (step) begin
         case (phase_ff)
            bmpd_pkg::PH_HEADER: begin
               count_in  = count_ff + 32'd1;
               sig_in    = 16'(put_le({16'd0, sig_ff}, hdr_idx, bmpd_pkg::SIG_AT, 3'd2,
                                      data_byte));
               ofs_in    = put_le(ofs_ff, hdr_idx, bmpd_pkg::OFS_AT, 3'd4, data_byte);
               info_in   = put_le(info_ff, hdr_idx, bmpd_pkg::INFO_AT, 3'd4, data_byte);
               width_in  = put_le(width_ff, hdr_idx, bmpd_pkg::WIDTH_AT, 3'd4, data_byte);
               height_in = put_le(height_ff, hdr_idx, bmpd_pkg::HEIGHT_AT, 3'd4, data_byte);
               bpp_in    = 16'(put_le({16'd0, bpp_ff}, hdr_idx, bmpd_pkg::BPP_AT, 3'd2,
                                      data_byte));
               comp_in   = put_le(comp_ff, hdr_idx, bmpd_pkg::COMP_AT, 3'd4, data_byte);
               if (hdr_idx == bmpd_pkg::SIG_AT + 6'd1 && sig_in != bmpd_pkg::SIG_BM) begin
                  err = bmpd_pkg::ERR_SIGNATURE;
               end else if (hdr_idx == bmpd_pkg::INFO_AT + 6'd3 &&
                            info_in != bmpd_pkg::INFO_LEN) begin
                  err = bmpd_pkg::ERR_VERSION;
               end else if (hdr_idx == bmpd_pkg::HDR_LAST) begin
                  if (bpp_ff != bmpd_pkg::BPP_24 || comp_ff != 32'd0) begin
                     err = bmpd_pkg::ERR_FORMAT;
                  end else if (width_ff > 32'(MAX_DIM) || height_ff > 32'(MAX_DIM)) begin
                     err = bmpd_pkg::ERR_TOO_LARGE;
                  end else if (ofs_ff < bmpd_pkg::HDR_LEN) begin
                     err = bmpd_pkg::ERR_OFFSET;
                  end else begin
                     // Header accepted: report dimensions and set up the frame walk.
                     res_valid  = 1'b1;
                     res.kind   = bmpd_pkg::KIND_HEADER;
                     res.width  = 13'(width_ff);
                     res.height = 13'(height_ff);
                     if (width_ff == 32'd0 || height_ff == 32'd0) begin
                        res.done = 1'b1;
                        phase_in = bmpd_pkg::PH_DRAIN;
                     end else begin
                        rows_in     = DIM_W'(height_ff);
                        row_base_in = 24'(base_prod);
                        column_in   = '0;
                        bip_in      = 2'd0;
                        phase_in    = (ofs_ff == bmpd_pkg::HDR_LEN) ? bmpd_pkg::PH_PIXEL
                                                                    : bmpd_pkg::PH_SKIP;
                     end
                  end
               end
            end
            bmpd_pkg::PH_SKIP: begin
               count_in = count_ff + 32'd1;
               if (count_in >= ofs_ff) begin
                  phase_in = bmpd_pkg::PH_PIXEL;
               end
            end
            bmpd_pkg::PH_PIXEL: begin
               if (bip_ff == 2'd0) begin
                  partial_in = {8'd0, data_byte};
                  bip_in     = 2'd1;
               end else if (bip_ff == 2'd1) begin
                  partial_in = {data_byte, partial_ff[7:0]};
                  bip_in     = 2'd2;
               end else begin
                  // Third byte completes the pixel.
                  bip_in    = 2'd0;
                  res_valid = 1'b1;
                  res.kind  = bmpd_pkg::KIND_PIXEL;
                  res.addr  = row_base_ff + 24'(column_ff);
                  if (swap_channels) begin
                     res.value = {partial_ff[7:0], partial_ff[15:8], data_byte};
                  end else begin
                     res.value = {data_byte, partial_ff};
                  end
                  column_in = col_inc;
                  if (col_inc >= DIM_W'(width_ff)) begin
                     column_in = '0;
                     rows_in   = rows_ff - DIM_W'(1);
                     if (rows_in == '0) begin
                        res.done = 1'b1;
                        phase_in = bmpd_pkg::PH_DRAIN;
                     end else begin
                        row_base_in = row_base_ff - 24'(width_ff);
                        if (width_ff[1:0] != 2'd0) begin
                           pad_in   = width_ff[1:0];
                           phase_in = bmpd_pkg::PH_PAD;
                        end
                     end
                  end
               end
            end
            bmpd_pkg::PH_PAD: begin
               pad_in = pad_ff - 2'd1;
               if (pad_in == 2'd0) begin
                  phase_in = bmpd_pkg::PH_PIXEL;
               end
            end
            default: begin
            end
         endcase

         // A failure replaces any other result and drains to end of file.
         if (err != bmpd_pkg::ERR_NONE) begin
            phase_in  = bmpd_pkg::PH_DRAIN;
            res_valid = 1'b1;
            res       = '0;
            res.kind  = bmpd_pkg::KIND_ERROR;
            res.code  = err;
            res.done  = 1'b1;
         end

         // End of file restarts the parser; unfinished work is a truncation.
         if (end_of_file) begin
            if (phase_in != bmpd_pkg::PH_DRAIN) begin
               res_valid = 1'b1;
               res       = '0;
               res.kind  = bmpd_pkg::KIND_ERROR;
               res.code  = bmpd_pkg::ERR_TRUNCATED;
               res.done  = 1'b1;
            end
            phase_in = bmpd_pkg::PH_HEADER;
            count_in = 32'd0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bmpd_pkg::PH_HEADER;
         count_ff <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Header fields and frame walk state; each is written before it is read.
   always_ff @(posedge clock) begin
      sig_ff      <= sig_in;
      ofs_ff      <= ofs_in;
      info_ff     <= info_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      bpp_ff      <= bpp_in;
      comp_ff     <= comp_in;
      bip_ff      <= bip_in;
      partial_ff  <= partial_in;
      column_ff   <= column_in;
      rows_ff     <= rows_in;
      row_base_ff <= row_base_in;
      pad_ff      <= pad_in;
   end

endmodule
